### rtl/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared constants for the sum-checked frame deframer.
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int unsigned SCFD_MAX_FRAME = 64;
  localparam int unsigned BYTE_W         = 8;
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd250;

endpackage

### rtl/sum_checked_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_unit
// Buffers received bytes in a circular window memory, scans for header/length
// framed packets, checks the modulo-256 sum and streams out valid frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  : one received serial byte per item.
//   m_axis_*  : validated frame bytes, header through checksum; tuser marks the
//               header byte, tlast the checksum byte.
//   cfg_*     : write of header_byte, always ready; write only while idle.
// Timing: an input item is taken only while the scanner is idle. After it the
//   scanner reads the window memory one entry per cycle through its single read
//   port, while the output does not stall: it tests a header, reads the length,
//   sums a candidate frame, then streams it out. A failed check drops one byte
//   and rescans before the input is free again.
// Reset: window empty, header_byte = 250; the memory is not cleared, since only
//   buffered entries are ever read.
// Stall: m_axis_tready low holds the output register and the streaming pass;
//   input is refused until the scan is idle again.
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer_unit
  import scfd_pkg::*;
#(
  parameter int unsigned MAX_FRAME = SCFD_MAX_FRAME
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] frame_byte
  output logic              m_axis_tuser,   // [0] is_first
  output logic              m_axis_tlast,   // is_last
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data        // [7:0] header_byte
);

  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam int unsigned CW = $clog2(MAX_FRAME + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]        state, state_next;
  logic [AW-1:0]     start, start_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     tot, tot_next;
  logic [AW-1:0]     idx, idx_next;
  logic [BYTE_W-1:0] sum, sum_next;
  logic [BYTE_W-1:0] header_byte;

  logic [BYTE_W-1:0] mem [MAX_FRAME];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rdata;

  logic              out_load;
  logic              out_first, out_last;
  logic [8:0]        len_total;
  logic              idx_is_last;
  logic              out_free;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_FRAME)) begin
      s = s - (CW+1)'(MAX_FRAME);
    end
    return AW'(s);
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign len_total     = {1'b0, rdata} + 9'd2;
  assign idx_is_last   = (CW'(idx) == tot - CW'(1));
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign wr_addr       = wrap(start, count);
  assign rd_addr       = wrap(start, CW'(rd_idx));

  always_comb begin
    state_next = state;
    start_next = start;
    count_next = count;
    tot_next   = tot;
    idx_next   = idx;
    sum_next   = sum;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_idx     = '0;
    out_load   = 1'b0;
    out_first  = 1'b0;
    out_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          wr_en = 1'b1;
          // full window: drop the oldest byte, the new one takes its slot
          if (count >= CW'(MAX_FRAME)) begin
            start_next = wrap(start, CW'(1));
          end else begin
            count_next = count + CW'(1);
          end
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (count == '0) begin
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = '0;
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        if (rdata != header_byte) begin
          start_next = wrap(start, CW'(1));
          count_next = count - CW'(1);
          state_next = S_SCAN;
        end else if (count < CW'(2)) begin
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = AW'(1);
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (len_total > 9'(MAX_FRAME)) begin
          start_next = wrap(start, CW'(1));
          count_next = count - CW'(1);
          state_next = S_SCAN;
        end else if (9'(count) < len_total) begin
          state_next = S_IDLE;
        end else begin
          tot_next   = CW'(len_total);
          sum_next   = header_byte;
          rd_en      = 1'b1;
          rd_idx     = AW'(1);
          idx_next   = AW'(1);
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (idx_is_last) begin
          if (sum == rdata) begin
            rd_en      = 1'b1;
            rd_idx     = '0;
            idx_next   = '0;
            state_next = S_EMIT;
          end else begin
            start_next = wrap(start, CW'(1));
            count_next = count - CW'(1);
            state_next = S_SCAN;
          end
        end else begin
          sum_next = sum + rdata;
          rd_en    = 1'b1;
          rd_idx   = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end
      S_EMIT: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          out_load  = 1'b1;
          out_first = (idx == '0);
          out_last  = idx_is_last;
          if (idx_is_last) begin
            start_next = wrap(start, tot);
            count_next = count - tot;
            state_next = S_SCAN;
          end else begin
            rd_en    = 1'b1;
            rd_idx   = idx + AW'(1);
            idx_next = idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start         <= '0;
      count         <= '0;
      header_byte   <= HEADER_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      start <= start_next;
      count <= count_next;
      if (cfg_valid) begin
        header_byte <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tot <= tot_next;
    idx <= idx_next;
    sum <= sum_next;
    if (out_load) begin
      m_axis_tdata <= rdata;
      m_axis_tuser <= out_first;
      m_axis_tlast <= out_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_FRAME))
    else $error("window count exceeds depth");

  a_frame_removed: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_load && out_last) |=> count == $past(count) - $past(tot))
    else $error("emitted frame not removed from window");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
    else $error("frame byte marked both first and last");
`endif

endmodule
